>>> rtl/core/handle_allocator_with_entry_table_top_macros.svh
// Assertion macros for the handle allocator.
`ifndef HANDLE_ALLOCATOR_WITH_ENTRY_TABLE_TOP_MACROS_SVH
`define HANDLE_ALLOCATOR_WITH_ENTRY_TABLE_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define HA_CHECK(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define HA_CHECK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/hdl_alloc_pkg.sv
// Types and constants of the handle allocator.
package hdl_alloc_pkg;

	localparam int HANDLE_W = 6;
	localparam int HEAP_W   = 10;
	localparam int COORD_W  = 8;
	localparam int COUNT_W  = 7;
	localparam int TILE_W   = 3 * COORD_W;
	localparam int ENTRY_W  = HEAP_W + TILE_W;

	localparam logic [1:0] KIND_ALLOC  = 2'd0;
	localparam logic [1:0] KIND_REMOVE = 2'd1;
	localparam logic [1:0] KIND_LIST   = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_NOTALLOC = 2'd2;
	localparam logic [1:0] ST_EMPTY    = 2'd3;

	typedef struct packed {
		logic [1:0]          kind;
		logic [HEAP_W-1:0]   heap_index;
		logic [COORD_W-1:0]  tile_x;
		logic [COORD_W-1:0]  tile_y;
		logic [COORD_W-1:0]  tile_z;
		logic [HANDLE_W-1:0] handle;
	} req_t;

	typedef struct packed {
		logic [1:0]          status;
		logic [HANDLE_W-1:0] out_handle;
		logic [HEAP_W-1:0]   out_heap_index;
		logic [COORD_W-1:0]  out_tile_x;
		logic [COORD_W-1:0]  out_tile_y;
		logic [COORD_W-1:0]  out_tile_z;
		logic [COUNT_W-1:0]  free_count;
		logic                last;
	} rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ALLOC_RD,
		S_ALLOC_WR,
		S_REMOVE,
		S_LIST,
		S_EMIT
	} state_t;

endpackage

>>> rtl/core/hdl_alloc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hdl_alloc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> rtl/core/handle_allocator_with_entry_table_top.sv
// Top level of the handle allocator: free stack, entry table and sequencer.
// Allocate passes through ALLOC_RD and, unless full, ALLOC_WR, then EMIT; remove through REMOVE and EMIT.
// List: scans the table entries in order and emits each valid entry it finds.
// One item at a time: the next item is taken once the last result is registered.
// Each step uses at most one access per port of the free-stack RAM and the entry-table RAM.
// Reset clears valid marks and stack written marks at once; no clearing pass is needed.
`include "handle_allocator_with_entry_table_top_macros.svh"

module handle_allocator_with_entry_table_top #(
	parameter int NUM_ENTRIES = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  hdl_alloc_pkg::req_t  req,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output hdl_alloc_pkg::rsp_t  rsp
);

	import hdl_alloc_pkg::*;

	localparam int IW = $clog2(NUM_ENTRIES);
	localparam int CW = $clog2(NUM_ENTRIES + 1);
	localparam logic [HANDLE_W:0] NUM_H = (HANDLE_W + 1)'(NUM_ENTRIES);
	localparam logic [CW-1:0]     NUM_C = CW'(NUM_ENTRIES);

	state_t state_q, state_d;

	req_t                item_q;
	logic [CW-1:0]       free_top_q;
	logic [NUM_ENTRIES-1:0] valid_q;
	logic [NUM_ENTRIES-1:0] stack_wr_q;
	logic [IW-1:0]       idx_q;
	logic                stack_wr_bit_q;
	logic [1:0]          res_status_q;
	logic [HANDLE_W-1:0] res_handle_q;
	logic                res_data_q;
	logic                res_last_q;
	logic                res_more_q;
	rsp_t                rsp_q;
	logic                rsp_valid_q;

	logic                accept;
	logic                out_free;
	logic [IW-1:0]       top_pos;
	logic [IW-1:0]       push_pos;
	logic [IW-1:0]       alloc_h;
	logic [IW-1:0]       rem_h;
	logic                rem_ok;
	logic                any_valid;
	logic [NUM_ENTRIES-1:0] above;
	logic                more_above;

	logic                stack_rd_en;
	logic                stack_wr_en;
	logic                tbl_rd_en;
	logic                tbl_wr_en;
	logic [IW-1:0]       tbl_rd_addr;
	logic                rsp_load;
	logic [IW-1:0]       stack_rdata;
	logic [ENTRY_W-1:0]  tbl_rdata;

	assign accept    = req_valid && !req_stall;
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign top_pos   = IW'(free_top_q - CW'(1));
	assign push_pos  = IW'(free_top_q);
	assign alloc_h   = stack_wr_bit_q ? stack_rdata : top_pos;
	assign rem_h     = item_q.handle[IW-1:0];
	assign rem_ok    = ({1'b0, item_q.handle} < NUM_H) && valid_q[rem_h] && (free_top_q < NUM_C);
	assign any_valid = |valid_q;

	always_comb begin
		for (int i = 0; i < NUM_ENTRIES; i++) begin
			above[i] = valid_q[i] && (i > int'(idx_q));
		end
	end

	assign more_above = |above;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (req.kind)
						KIND_ALLOC:  state_d = S_ALLOC_RD;
						KIND_REMOVE: state_d = S_REMOVE;
						KIND_LIST:   state_d = any_valid ? S_LIST : S_EMIT;
						default:     state_d = S_IDLE;
					endcase
				end
			end
			S_ALLOC_RD: state_d = (free_top_q == '0) ? S_EMIT : S_ALLOC_WR;
			S_ALLOC_WR: state_d = S_EMIT;
			S_REMOVE:   state_d = S_EMIT;
			S_LIST:     state_d = valid_q[idx_q] ? S_EMIT : S_LIST;
			S_EMIT: begin
				if (out_free) begin
					state_d = res_more_q ? S_LIST : S_IDLE;
				end
			end
			default:    state_d = S_IDLE;
		endcase
	end

	always_comb begin
		req_stall   = 1'b1;
		stack_rd_en = 1'b0;
		stack_wr_en = 1'b0;
		tbl_rd_en   = 1'b0;
		tbl_wr_en   = 1'b0;
		tbl_rd_addr = rem_h;
		rsp_load    = 1'b0;
		unique case (state_q)
			S_IDLE:     req_stall = 1'b0;
			S_ALLOC_RD: stack_rd_en = (free_top_q != '0);
			S_ALLOC_WR: tbl_wr_en = 1'b1;
			S_REMOVE: begin
				stack_wr_en = rem_ok;
				tbl_rd_en   = rem_ok;
			end
			S_LIST: begin
				tbl_rd_en   = valid_q[idx_q];
				tbl_rd_addr = idx_q;
			end
			S_EMIT:     rsp_load = out_free;
			default:    req_stall = 1'b1;
		endcase
	end

	hdl_alloc_ram #(
		.WIDTH (IW),
		.DEPTH (NUM_ENTRIES)
	) u_stack_ram (
		.clk     (clk),
		.wr_en   (stack_wr_en),
		.wr_addr (push_pos),
		.wr_data (rem_h),
		.rd_en   (stack_rd_en),
		.rd_addr (top_pos),
		.rd_data (stack_rdata)
	);

	hdl_alloc_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (NUM_ENTRIES)
	) u_table_ram (
		.clk     (clk),
		.wr_en   (tbl_wr_en),
		.wr_addr (alloc_h),
		.wr_data ({item_q.heap_index, item_q.tile_z, item_q.tile_y, item_q.tile_x}),
		.rd_en   (tbl_rd_en),
		.rd_addr (tbl_rd_addr),
		.rd_data (tbl_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			free_top_q  <= NUM_C;
			valid_q     <= '0;
			stack_wr_q  <= '0;
			idx_q       <= '0;
			res_more_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				idx_q      <= '0;
				res_more_q <= 1'b0;
			end
			if (tbl_wr_en) begin
				free_top_q       <= free_top_q - CW'(1);
				valid_q[alloc_h] <= 1'b1;
			end
			if (stack_wr_en) begin
				free_top_q           <= free_top_q + CW'(1);
				valid_q[rem_h]       <= 1'b0;
				stack_wr_q[push_pos] <= 1'b1;
			end
			if (state_q == S_LIST) begin
				if (valid_q[idx_q]) begin
					res_more_q <= more_above;
				end else begin
					idx_q <= idx_q + IW'(1);
				end
			end
			if (rsp_load && res_more_q) begin
				idx_q <= idx_q + IW'(1);
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= req;
		end
		if (stack_rd_en) begin
			stack_wr_bit_q <= stack_wr_q[top_pos];
		end
		if (accept && req.kind == KIND_LIST && !any_valid) begin
			res_status_q <= ST_EMPTY;
			res_handle_q <= '0;
			res_data_q   <= 1'b0;
			res_last_q   <= 1'b1;
		end
		if (state_q == S_ALLOC_RD && free_top_q == '0) begin
			res_status_q <= ST_FULL;
			res_handle_q <= '0;
			res_data_q   <= 1'b0;
			res_last_q   <= 1'b1;
		end
		if (state_q == S_ALLOC_WR) begin
			res_status_q <= ST_OK;
			res_handle_q <= HANDLE_W'(alloc_h);
			res_data_q   <= 1'b0;
			res_last_q   <= 1'b1;
		end
		if (state_q == S_REMOVE) begin
			res_status_q <= rem_ok ? ST_OK : ST_NOTALLOC;
			res_handle_q <= item_q.handle;
			res_data_q   <= rem_ok;
			res_last_q   <= 1'b1;
		end
		if (state_q == S_LIST && valid_q[idx_q]) begin
			res_status_q <= ST_OK;
			res_handle_q <= HANDLE_W'(idx_q);
			res_data_q   <= 1'b1;
			res_last_q   <= !more_above;
		end
		if (rsp_load) begin
			rsp_q.status         <= res_status_q;
			rsp_q.out_handle     <= res_handle_q;
			rsp_q.out_heap_index <= res_data_q ? tbl_rdata[ENTRY_W-1 -: HEAP_W] : '0;
			rsp_q.out_tile_z     <= res_data_q ? tbl_rdata[2*COORD_W +: COORD_W] : '0;
			rsp_q.out_tile_y     <= res_data_q ? tbl_rdata[COORD_W +: COORD_W] : '0;
			rsp_q.out_tile_x     <= res_data_q ? tbl_rdata[0 +: COORD_W] : '0;
			rsp_q.free_count     <= COUNT_W'(free_top_q);
			rsp_q.last           <= res_last_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`HA_CHECK(a_count_sum, 1'b1, ($countones(valid_q) + int'(free_top_q)) == NUM_ENTRIES, "handle count mismatch")
	`HA_CHECK_NEXT(a_push_top, stack_wr_en, free_top_q == CW'($past(free_top_q) + CW'(1)), "free top not advanced on release")
	`HA_CHECK(a_full_count, rsp_valid && rsp.status == ST_FULL, rsp.free_count == '0, "full reported with free handles")

endmodule
